// ===== hw/rtl/spq_pkg.sv =====
`default_nettype none

package spq_pkg;

  // operation codes
  localparam logic OP_ENQ = 1'b0;
  localparam logic OP_DEQ = 1'b1;

  // result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  // command broadcast to every cell of the chain
  typedef struct packed {
    logic               ins;
    logic               del;
    logic signed [31:0] value;
    logic signed [31:0] prio;
  } spq_cmd_t;

endpackage

`default_nettype wire

// ===== hw/rtl/spq_if.sv =====
`default_nettype none

// input channel: one queue operation per transfer
interface spq_in_if;
  logic               valid;
  logic               ready;
  logic               op;
  logic signed [31:0] value;
  logic signed [31:0] prio;

  modport source (output valid, output op, output value, output prio, input ready);
  modport sink   (input valid, input op, input value, input prio, output ready);
endinterface

// output channel: one result per transfer
interface spq_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] out_value;
  logic [1:0]         status;
  logic [7:0]         occupancy;

  modport source (output valid, output out_value, output status, output occupancy,
                  input ready);
  modport sink   (input valid, input out_value, input status, input occupancy,
                  output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/spq_cell.sv =====
`default_nettype none

module spq_cell
  import spq_pkg::*;
(
  input  wire logic               clk_i,
  input  wire spq_cmd_t           cmd_i,
  input  wire logic               occ_i,
  input  wire logic               left_occ_i,
  input  wire logic               left_gt_i,
  input  wire logic signed [31:0] left_value_i,
  input  wire logic signed [31:0] left_prio_i,
  input  wire logic signed [31:0] right_value_i,
  input  wire logic signed [31:0] right_prio_i,
  output logic                    gt_o,
  output logic signed [31:0]      value_o,
  output logic signed [31:0]      prio_o
);

  logic signed [31:0] value_q, value_d;
  logic signed [31:0] prio_q, prio_d;
  logic               shift_in, place_new;

  // stored entry ranks strictly behind the incoming priority
  assign gt_o = occ_i && (prio_q > cmd_i.prio);

  // insert: take the left neighbour when it moves on, or the new entry at the boundary
  assign shift_in  = cmd_i.ins && left_gt_i;
  assign place_new = cmd_i.ins && !left_gt_i && left_occ_i && (gt_o || !occ_i);

  always_comb begin
    value_d = value_q;
    prio_d  = prio_q;
    if (shift_in) begin
      value_d = left_value_i;
      prio_d  = left_prio_i;
    end else if (place_new) begin
      value_d = cmd_i.value;
      prio_d  = cmd_i.prio;
    end else if (cmd_i.del) begin
      // remove: everything moves one place towards the head
      value_d = right_value_i;
      prio_d  = right_prio_i;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    value_q <= value_d;
    prio_q  <= prio_d;
  end

  assign value_o = value_q;
  assign prio_o  = prio_q;

endmodule

`default_nettype wire

// ===== hw/rtl/sorted_priority_queue_unit.sv =====
// Sorted priority queue built as a row of DEPTH compare-and-shift cells, head at cell 0.
// Each transfer on in_i is an enqueue (op 0) or a dequeue (op 1); each gives exactly one
// result on out_o with the dequeued value, a status (ok, full and dropped, empty) and the
// count after the step. Entries of equal priority leave in arrival order; smaller signed
// priority leaves first. One operation is taken every clock cycle: all cells compare the
// incoming priority against their own in parallel and shift by one place in the same
// cycle, and the result sits in an output register so that a new operation is taken in
// the same cycle as the previous result transfers. The only stall is a held result with
// out_o.ready low. No clearing pass is needed after reset.
`default_nettype none

module sorted_priority_queue_unit
  import spq_pkg::*;
#(
  parameter int unsigned DEPTH = 128
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  spq_in_if.sink    in_i,
  spq_out_if.source out_o
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [CntW-1:0]      count_q, count_d;
  logic                 out_valid_q;
  logic signed [31:0]   out_value_q, out_value_d;
  logic [1:0]           status_q, status_d;
  logic [7:0]           occ_out_q;
  logic [CntW+7:0]      count_wide;
  logic                 take, full, empty;
  spq_cmd_t             cmd;

  logic [DEPTH-1:0]        occ, gt;
  logic signed [31:0]      cell_value [DEPTH];
  logic signed [31:0]      cell_prio  [DEPTH];

  // accept while the result register is free or being emptied
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign take       = in_i.valid && in_i.ready;
  assign full       = (count_q == CntW'(DEPTH));
  assign empty      = (count_q == '0);

  // command for the cell row
  always_comb begin
    cmd.ins   = take && (in_i.op == OP_ENQ) && !full;
    cmd.del   = take && (in_i.op == OP_DEQ) && !empty;
    cmd.value = in_i.value;
    cmd.prio  = in_i.prio;
  end

  // fill level and result
  always_comb begin
    count_d     = count_q;
    status_d    = ST_OK;
    out_value_d = '0;
    if (in_i.op == OP_ENQ) begin
      if (full) status_d = ST_FULL;
      else      count_d  = count_q + CntW'(1);
    end else begin
      if (empty) begin
        status_d = ST_EMPTY;
      end else begin
        count_d     = count_q - CntW'(1);
        out_value_d = cell_value[0];
      end
    end
  end

  assign count_wide = {8'd0, count_d};

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (take) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (take) begin
      out_value_q <= out_value_d;
      status_q    <= status_d;
      occ_out_q   <= count_wide[7:0];
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.out_value = out_value_q;
  assign out_o.status    = status_q;
  assign out_o.occupancy = occ_out_q;

  // the cell row
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic               l_occ, l_gt;
    logic signed [31:0] l_value, l_prio, r_value, r_prio;

    assign occ[i] = CntW'(i) < count_q;

    if (i == 0) begin : g_head
      assign l_occ   = 1'b1;
      assign l_gt    = 1'b0;
      assign l_value = '0;
      assign l_prio  = '0;
    end else begin : g_body
      assign l_occ   = occ[i-1];
      assign l_gt    = gt[i-1];
      assign l_value = cell_value[i-1];
      assign l_prio  = cell_prio[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign r_value = '0;
      assign r_prio  = '0;
    end else begin : g_inner
      assign r_value = cell_value[i+1];
      assign r_prio  = cell_prio[i+1];
    end

    spq_cell u_cell (
      .clk_i        (clk_i),
      .cmd_i        (cmd),
      .occ_i        (occ[i]),
      .left_occ_i   (l_occ),
      .left_gt_i    (l_gt),
      .left_value_i (l_value),
      .left_prio_i  (l_prio),
      .right_value_i(r_value),
      .right_prio_i (r_prio),
      .gt_o         (gt[i]),
      .value_o      (cell_value[i]),
      .prio_o       (cell_prio[i])
    );
  end

endmodule

`default_nettype wire

// ===== hw/rtl/spq_checker.sv =====
`default_nettype none

module spq_checker
  import spq_pkg::*;
#(
  parameter int unsigned DEPTH = 128
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  input  wire logic        in_ready_i,
  input  wire logic        out_valid_i,
  input  wire logic        out_ready_i,
  input  wire logic [31:0] out_value_i,
  input  wire logic [1:0]  status_i,
  input  wire logic [7:0]  occupancy_i
);

  localparam logic [31:0] DepthW = 32'(DEPTH);

  // a held result stays until its transfer
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(status_i)
      && $stable(out_value_i) && $stable(occupancy_i))
    else $error("result changed while stalled");

  // empty dequeue reports zero value and an empty queue
  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i == ST_EMPTY |-> out_value_i == '0 && occupancy_i == '0)
    else $error("empty dequeue result wrong");

  // dropped enqueue only when the queue is at full depth
  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i == ST_FULL |-> out_value_i == '0 && occupancy_i == DepthW[7:0])
    else $error("full result wrong");

  // an input transfer always leaves a result pending
  a_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> out_valid_i)
    else $error("transfer produced no result");

endmodule

bind sorted_priority_queue_unit spq_checker #(.DEPTH(DEPTH)) u_spq_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_i.valid),
  .in_ready_i (in_i.ready),
  .out_valid_i(out_o.valid),
  .out_ready_i(out_o.ready),
  .out_value_i(out_o.out_value),
  .status_i   (out_o.status),
  .occupancy_i(out_o.occupancy)
);

`default_nettype wire
